// ===== rtl/slot_linked_list_manager_assert.svh =====
// ---------------------------------------------------------------------------
// slot_linked_list_manager_assert.svh
// Assertion macros for the slot linked list manager.
// ---------------------------------------------------------------------------
`ifndef SLOT_LINKED_LIST_MANAGER_ASSERT_SVH
`define SLOT_LINKED_LIST_MANAGER_ASSERT_SVH

`ifndef SYNTH

// Invariant checked at every clock edge out of reset
`define SLLM_ASSERT(lbl, clk_s, rstn_s, cond) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (cond)) \
        else $error("sllm invariant violated");

// Implication checked at every clock edge out of reset
`define SLLM_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("sllm implication violated");

`else

`define SLLM_ASSERT(lbl, clk_s, rstn_s, cond)
`define SLLM_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

// ===== rtl/sllm_pkg.sv =====
// ---------------------------------------------------------------------------
// sllm_pkg
// Shared constants, codes and the result record of the slot list manager.
// ---------------------------------------------------------------------------
`default_nettype none

package sllm_pkg;

    localparam int SLOTS_DEFAULT = 32;
    localparam int FIELD_W       = 5;
    localparam int CMD_W         = 2;
    localparam int ST_W          = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_NEXT   = 2'd2
    } cmd_e;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_e;

    typedef struct packed {
        logic [FIELD_W-1:0] slot_index;
        logic [FIELD_W-1:0] next_iterator;
        logic [ST_W-1:0]    status;
        logic [FIELD_W-1:0] entry_count;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/sllm_ram.sv =====
// ---------------------------------------------------------------------------
// sllm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module sllm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/sllm_outbuf.sv =====
// ---------------------------------------------------------------------------
// sllm_outbuf
// Output register: holds one finished result item until the sink takes it.
// ---------------------------------------------------------------------------
`default_nettype none

module sllm_outbuf (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load_valid,
    output logic                               load_ready,
    input  wire sllm_pkg::res_t                load_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [sllm_pkg::FIELD_W-1:0]       slot_index,
    output logic [sllm_pkg::FIELD_W-1:0]       next_iterator,
    output logic [sllm_pkg::ST_W-1:0]          status,
    output logic [sllm_pkg::FIELD_W-1:0]       entry_count
);

    import sllm_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t data_reg;

    assign load_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (out_ready)
        begin
            valid_next = 1'b0;
        end
        if (load_valid && load_ready)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid     = valid_reg;
    assign slot_index    = data_reg.slot_index;
    assign next_iterator = data_reg.next_iterator;
    assign status        = data_reg.status;
    assign entry_count   = data_reg.entry_count;

endmodule

`default_nettype wire

// ===== rtl/slot_linked_list_manager.sv =====
// ---------------------------------------------------------------------------
// slot_linked_list_manager
// Circular insertion-ordered list over a table of slots; links kept in RAM.
// ---------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_ready  command, slot, iterator
//  out      out_valid/ out_ready slot_index, next_iterator, status, entry_count
//
//  One item at a time; in_ready is high whenever the controller is idle,
//  also while a result waits in the output register.
//  add:    scans the occupancy flops upward from slot 1 for the lowest free
//          slot (one slot per cycle), then links it; no scan when full.
//  delete: reads the victim's successor, then walks from head to the
//          predecessor (one link RAM read per cycle); no walk on a miss or last entry.
//  next:   one link RAM read. Every command waits while the output register is full.
//  Reset clears occupancy flops, head, tail and count; link RAM needs none.
// ---------------------------------------------------------------------------
`default_nettype none

`include "slot_linked_list_manager_assert.svh"

module slot_linked_list_manager #(
    parameter int SLOTS = sllm_pkg::SLOTS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [sllm_pkg::CMD_W-1:0]    command,
    input  wire logic [sllm_pkg::FIELD_W-1:0]  slot,
    input  wire logic [sllm_pkg::FIELD_W-1:0]  iterator,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [sllm_pkg::FIELD_W-1:0]       slot_index,
    output logic [sllm_pkg::FIELD_W-1:0]       next_iterator,
    output logic [sllm_pkg::ST_W-1:0]          status,
    output logic [sllm_pkg::FIELD_W-1:0]       entry_count
);

    import sllm_pkg::*;

    localparam int IW = $clog2(SLOTS);
    localparam int XW = ((IW > FIELD_W) ? IW : FIELD_W) + 1;
    localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_ADD_SCAN,
        S_ADD_LINK,
        S_ADD_TAIL,
        S_DEL_SUCC,
        S_DEL_WALK,
        S_NEXT_RD,
        S_RESP
    } state_t;

    state_t              state_reg, state_next;
    cmd_e                cmd_reg, cmd_next;
    logic [FIELD_W-1:0]  slot_in_reg, slot_in_next;
    logic [FIELD_W-1:0]  iter_in_reg, iter_in_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [IW-1:0]       succ_reg, succ_next;
    logic [IW-1:0]       head_reg, head_next;
    logic [IW-1:0]       tail_reg, tail_next;
    logic [IW-1:0]       count_reg, count_next;
    logic [SLOTS-1:0]    occ_reg, occ_next;
    res_t                res_reg, res_next;

    logic                ram_we;
    logic [IW-1:0]       ram_waddr;
    logic [IW-1:0]       ram_wdata;
    logic [IW-1:0]       ram_raddr;
    logic [IW-1:0]       ram_rdata;

    logic                res_valid;
    logic                res_ready;

    logic [XW-1:0]       slot_x;
    logic [XW-1:0]       iter_x;
    logic [IW-1:0]       slot_idx;
    logic [IW-1:0]       iter_idx;
    logic                slot_used;
    logic                iter_used;

    assign slot_x    = XW'(slot_in_reg);
    assign iter_x    = XW'(iter_in_reg);
    assign slot_idx  = slot_x[IW-1:0];
    assign iter_idx  = iter_x[IW-1:0];
    assign slot_used = (slot_x != '0) && (slot_x < XW'(SLOTS)) && occ_reg[slot_idx];
    assign iter_used = (iter_x != '0) && (iter_x < XW'(SLOTS)) && occ_reg[iter_idx];

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        slot_in_next = slot_in_reg;
        iter_in_next = iter_in_reg;
        idx_next     = idx_reg;
        succ_next    = succ_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        occ_next     = occ_reg;
        res_next     = res_reg;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg;
        ram_wdata    = head_reg;
        ram_raddr    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next     = cmd_e'(command);
                    slot_in_next = slot;
                    iter_in_next = iterator;
                    state_next   = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                res_next.slot_index    = '0;
                res_next.next_iterator = '0;
                res_next.status        = ST_OK;
                res_next.entry_count   = FIELD_W'(count_reg);
                state_next             = S_RESP;
                case (cmd_reg)
                    CMD_ADD:
                    begin
                        if (count_reg == LAST_SLOT)
                        begin
                            res_next.status = ST_FULL;
                        end
                        else
                        begin
                            idx_next   = IW'(1);
                            state_next = S_ADD_SCAN;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (!slot_used)
                        begin
                            res_next.status = ST_NOT_FOUND;
                        end
                        else if (count_reg == IW'(1))
                        begin
                            occ_next[slot_idx]   = 1'b0;
                            head_next            = '0;
                            tail_next            = '0;
                            count_next           = '0;
                            res_next.entry_count = '0;
                        end
                        else
                        begin
                            ram_raddr  = slot_idx;
                            state_next = S_DEL_SUCC;
                        end
                    end
                    CMD_NEXT:
                    begin
                        if (!iter_used)
                        begin
                            res_next.status = ST_NOT_FOUND;
                        end
                        else
                        begin
                            ram_raddr  = iter_idx;
                            state_next = S_NEXT_RD;
                        end
                    end
                    default:
                    begin
                        res_next.status = ST_OK;
                    end
                endcase
            end

            // not full, so a free slot turns up before the end
            S_ADD_SCAN:
            begin
                if (!occ_reg[idx_reg])
                begin
                    state_next = S_ADD_LINK;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end

            // occupancy flag is set together with the count update
            S_ADD_LINK:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                if (count_reg == '0)
                begin
                    ram_wdata              = idx_reg;
                    occ_next[idx_reg]      = 1'b1;
                    head_next              = idx_reg;
                    tail_next              = idx_reg;
                    count_next             = IW'(1);
                    res_next.slot_index    = FIELD_W'(idx_reg);
                    res_next.entry_count   = FIELD_W'(IW'(1));
                    state_next             = S_RESP;
                end
                else
                begin
                    ram_wdata  = head_reg;
                    state_next = S_ADD_TAIL;
                end
            end

            S_ADD_TAIL:
            begin
                ram_we               = 1'b1;
                ram_waddr            = tail_reg;
                ram_wdata            = idx_reg;
                occ_next[idx_reg]    = 1'b1;
                tail_next            = idx_reg;
                count_next           = count_reg + IW'(1);
                res_next.slot_index  = FIELD_W'(idx_reg);
                res_next.entry_count = FIELD_W'(count_reg + IW'(1));
                state_next           = S_RESP;
            end

            S_DEL_SUCC:
            begin
                succ_next  = ram_rdata;
                ram_raddr  = head_reg;
                idx_next   = head_reg;
                state_next = S_DEL_WALK;
            end

            // walk from head; the entry linking to the victim is its predecessor
            S_DEL_WALK:
            begin
                if (ram_rdata == slot_idx)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg;
                    ram_wdata = succ_reg;
                    if (head_reg == slot_idx)
                    begin
                        head_next = succ_reg;
                    end
                    if (tail_reg == slot_idx)
                    begin
                        tail_next = idx_reg;
                    end
                    occ_next[slot_idx]   = 1'b0;
                    count_next           = count_reg - IW'(1);
                    res_next.entry_count = FIELD_W'(count_reg - IW'(1));
                    state_next           = S_RESP;
                end
                else
                begin
                    idx_next  = ram_rdata;
                    ram_raddr = ram_rdata;
                end
            end

            S_NEXT_RD:
            begin
                res_next.slot_index    = FIELD_W'(iter_idx);
                res_next.next_iterator = (iter_idx == tail_reg) ? '0 : FIELD_W'(ram_rdata);
                state_next             = S_RESP;
            end

            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cmd_reg     <= CMD_ADD;
            slot_in_reg <= '0;
            iter_in_reg <= '0;
            idx_reg     <= '0;
            succ_reg    <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            occ_reg     <= '0;
            res_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cmd_reg     <= cmd_next;
            slot_in_reg <= slot_in_next;
            iter_in_reg <= iter_in_next;
            idx_reg     <= idx_next;
            succ_reg    <= succ_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            occ_reg     <= occ_next;
            res_reg     <= res_next;
        end
    end

    sllm_ram #(
        .WIDTH (IW),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sllm_outbuf u_outbuf (
        .clk           (clk),
        .rst_n         (rst_n),
        .load_valid    (res_valid),
        .load_ready    (res_ready),
        .load_data     (res_reg),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .slot_index    (slot_index),
        .next_iterator (next_iterator),
        .status        (status),
        .entry_count   (entry_count)
    );

    // occupancy flops and the count must agree; slot 0 is never taken
    `SLLM_ASSERT(a_count_matches_occ, clk, rst_n, ($countones(occ_reg) == int'(count_reg)) && !occ_reg[0])
    `SLLM_ASSERT(a_head_zero_iff_empty, clk, rst_n, (count_reg == '0) == (head_reg == '0))
    `SLLM_ASSERT_IMP(a_ends_occupied, clk, rst_n, count_reg != '0, occ_reg[head_reg] && occ_reg[tail_reg])

endmodule

`default_nettype wire
